[rtl/fcgi_pkg.sv]
// Shared types, codes and helpers for the FastCGI record deframer.
package fcgi_pkg;

    localparam int unsigned HDR_BYTES = 8;
    localparam logic [7:0] FCGI_VERSION = 8'd1;
    localparam logic [7:0] TYPE_PARAMS = 8'd4;
    localparam logic [7:0] TYPE_STDIN = 8'd5;

    typedef enum logic [2:0] {
        CLS_HEADER   = 3'd0,
        CLS_PAIR_LEN = 3'd1,
        CLS_NAME     = 3'd2,
        CLS_VALUE    = 3'd3,
        CLS_STDIN    = 3'd4,
        CLS_OTHER    = 3'd5,
        CLS_PADDING  = 3'd6
    } byte_class_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_VERSION  = 3'd1,
        ERR_REQUEST  = 3'd2,
        ERR_TYPE     = 3'd3,
        ERR_LONG_LEN = 3'd4,
        ERR_OVERRUN  = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        PH_NAME_LEN  = 2'd0,
        PH_VALUE_LEN = 2'd1,
        PH_BYTES     = 2'd2
    } pair_phase_t;

    // Record types that the responder role understands.
    function automatic logic type_known(input logic [7:0] t);
        type_known = (t == 8'd1) || (t == 8'd3) || (t == 8'd4) ||
                     (t == 8'd5) || (t == 8'd6) || (t == 8'd7);
    endfunction

endpackage

[rtl/fastcgi_record_deframer_core.sv]
// FastCGI record deframer: splits a byte stream into tagged records and pairs.
//
// The slave channel takes one message byte per beat; s_tlast marks the last
// byte of a message. Each accepted byte produces exactly one master beat that
// carries the byte back with its class, the current record type and request
// id, a sticky error code, a pair-end flag in tuser and a record-end flag on
// m_tlast.
// The result of a byte is registered: a byte accepted at one edge is shown on
// the master side from that edge on. Throughput is one byte per cycle while the
// receiver does not stall; the only storage between the channels is the result
// register, and the framing counters update in the same cycle as the accept.
// When the receiver stalls, the result register holds its beat and
// s_tready falls, so no further byte is taken until the beat leaves; a beat
// leaving and a new byte arriving may share a cycle.
// After reset all framing state, the request latch and the error are clear
// and the next byte is taken as the first header byte of a message. The
// same clearing, but for the record type and id, happens after every byte
// that carries s_tlast, so a truncated record is simply dropped.
module fastcgi_record_deframer_core
    import fcgi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // message_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] byte_value, [15:8] record_type,
                                   // [31:16] record_request, [34:32] error_code,
                                   // [39:35] zero
    output logic        m_tlast,   // record_end
    output logic [3:0]  m_tuser    // [2:0] byte_class, [3] pair_end
);

    // Framing state.
    logic [3:0]  hdr_pos_reg,  hdr_pos_next;
    logic [7:0]  cur_type_reg, cur_type_next;
    logic [15:0] cur_req_reg,  cur_req_next;
    logic [15:0] content_reg,  content_next;
    logic [7:0]  padding_reg,  padding_next;
    pair_phase_t phase_reg,    phase_next;
    logic [6:0]  name_reg,     name_next;
    logic [6:0]  value_reg,    value_next;
    logic [15:0] msg_req_reg,  msg_req_next;
    logic        latched_reg,  latched_next;
    err_t        err_reg,      err_next;

    // Result register.
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic        out_last_reg;
    logic [3:0]  out_user_reg;

    byte_class_t cls;
    logic        rec_end;
    logic        p_end;
    err_t        err_out;
    logic        accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        hdr_pos_next  = hdr_pos_reg;
        cur_type_next = cur_type_reg;
        cur_req_next  = cur_req_reg;
        content_next  = content_reg;
        padding_next  = padding_reg;
        phase_next    = phase_reg;
        name_next     = name_reg;
        value_next    = value_reg;
        msg_req_next  = msg_req_reg;
        latched_next  = latched_reg;
        err_next      = err_reg;
        cls           = CLS_HEADER;
        rec_end       = 1'b0;
        p_end         = 1'b0;

        if (hdr_pos_reg < 4'(HDR_BYTES))
        begin
            unique case (hdr_pos_reg[2:0])
                3'd0:
                begin
                    if (err_next == ERR_NONE && s_tdata != FCGI_VERSION)
                        err_next = ERR_VERSION;
                end
                3'd1:
                begin
                    cur_type_next = s_tdata;
                    if (err_next == ERR_NONE && !type_known(s_tdata))
                        err_next = ERR_TYPE;
                end
                3'd2:
                    cur_req_next = {s_tdata, cur_req_reg[7:0]};
                3'd3:
                begin
                    cur_req_next = {cur_req_reg[15:8], s_tdata};
                    if (!latched_reg)
                    begin
                        // An id of zero does not latch; a later header may.
                        msg_req_next = cur_req_next;
                        latched_next = (cur_req_next != 16'd0);
                    end
                    else if (msg_req_reg != cur_req_next && err_next == ERR_NONE)
                        err_next = ERR_REQUEST;
                end
                3'd4:
                    content_next = {s_tdata, content_reg[7:0]};
                3'd5:
                    content_next = {content_reg[15:8], s_tdata};
                3'd6:
                    padding_next = s_tdata;
                3'd7:
                begin
                    phase_next = PH_NAME_LEN;
                    name_next  = 7'd0;
                    value_next = 7'd0;
                end
            endcase
            hdr_pos_next = hdr_pos_reg + 4'd1;
        end
        else if (content_reg != 16'd0)
        begin
            content_next = content_reg - 16'd1;
            if (cur_type_reg == TYPE_PARAMS)
            begin
                case (phase_reg)
                    PH_NAME_LEN:
                    begin
                        cls = CLS_PAIR_LEN;
                        if (err_next == ERR_NONE && s_tdata[7])
                            err_next = ERR_LONG_LEN;
                        name_next  = s_tdata[6:0];
                        phase_next = PH_VALUE_LEN;
                    end
                    PH_VALUE_LEN:
                    begin
                        cls = CLS_PAIR_LEN;
                        if (err_next == ERR_NONE && s_tdata[7])
                            err_next = ERR_LONG_LEN;
                        value_next = s_tdata[6:0];
                        if (name_reg == 7'd0 && value_next == 7'd0)
                        begin
                            p_end      = 1'b1;
                            phase_next = PH_NAME_LEN;
                        end
                        else
                            phase_next = PH_BYTES;
                    end
                    default:
                    begin
                        if (name_reg != 7'd0)
                        begin
                            cls       = CLS_NAME;
                            name_next = name_reg - 7'd1;
                        end
                        else
                        begin
                            cls = CLS_VALUE;
                            if (value_reg != 7'd0)
                                value_next = value_reg - 7'd1;
                        end
                        if (name_next == 7'd0 && value_next == 7'd0)
                        begin
                            p_end      = 1'b1;
                            phase_next = PH_NAME_LEN;
                        end
                    end
                endcase
                // Content ran out: an unfinished pair is an overrun.
                if (content_next == 16'd0)
                begin
                    if (phase_next != PH_NAME_LEN && err_next == ERR_NONE)
                        err_next = ERR_OVERRUN;
                    phase_next = PH_NAME_LEN;
                    name_next  = 7'd0;
                    value_next = 7'd0;
                end
            end
            else if (cur_type_reg == TYPE_STDIN)
                cls = CLS_STDIN;
            else
                cls = CLS_OTHER;
        end
        else
        begin
            cls = CLS_PADDING;
            if (padding_reg != 8'd0)
                padding_next = padding_reg - 8'd1;
        end

        if (hdr_pos_next >= 4'(HDR_BYTES) && content_next == 16'd0 && padding_next == 8'd0)
        begin
            rec_end      = 1'b1;
            hdr_pos_next = 4'd0;
        end

        err_out = err_next;

        // End of message: start afresh with the next byte.
        if (s_tlast)
        begin
            hdr_pos_next = 4'd0;
            content_next = 16'd0;
            padding_next = 8'd0;
            phase_next   = PH_NAME_LEN;
            name_next    = 7'd0;
            value_next   = 7'd0;
            msg_req_next = 16'd0;
            latched_next = 1'b0;
            err_next     = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg   <= 4'd0;
            cur_type_reg  <= 8'd0;
            cur_req_reg   <= 16'd0;
            content_reg   <= 16'd0;
            padding_reg   <= 8'd0;
            phase_reg     <= PH_NAME_LEN;
            name_reg      <= 7'd0;
            value_reg     <= 7'd0;
            msg_req_reg   <= 16'd0;
            latched_reg   <= 1'b0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                hdr_pos_reg  <= hdr_pos_next;
                cur_type_reg <= cur_type_next;
                cur_req_reg  <= cur_req_next;
                content_reg  <= content_next;
                padding_reg  <= padding_next;
                phase_reg    <= phase_next;
                name_reg     <= name_next;
                value_reg    <= value_next;
                msg_req_reg  <= msg_req_next;
                latched_reg  <= latched_next;
                err_reg      <= err_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {5'd0, err_out, cur_req_next, cur_type_next, s_tdata};
            out_last_reg <= rec_end;
            out_user_reg <= {p_end, cls};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // The first error of a message holds until the message ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tlast && err_reg != ERR_NONE) |=> (err_reg == $past(err_reg)))
        else $error("sticky error changed within a message");

    // The header counter never runs past the end of the header.
    assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg <= 4'(HDR_BYTES))
        else $error("header position out of range");

    // A pair can only end on a params byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[3]) |->
            (m_tuser[2:0] == CLS_PAIR_LEN || m_tuser[2:0] == CLS_NAME ||
             m_tuser[2:0] == CLS_VALUE))
        else $error("pair end on a byte outside params content");

    // Pair state is clear whenever no params content is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (content_reg == 16'd0 && hdr_pos_reg == 4'(HDR_BYTES)) |->
            (phase_reg == PH_NAME_LEN && name_reg == 7'd0 && value_reg == 7'd0))
        else $error("pair state left over after content");
`endif

endmodule

[bench/tb_fastcgi_record_deframer_core.sv]
// Self-checking bench for the FastCGI record deframer core.
`timescale 1ns / 1ps

module tb_fastcgi_record_deframer_core;
    import fcgi_pkg::*;

    // Record types outside params and stdin; abort is not served by this block.
    localparam logic [7:0] TYPE_BEGIN_REQUEST = 8'd1;
    localparam logic [7:0] TYPE_ABORT_REQUEST = 8'd2;
    localparam logic [7:0] TYPE_END_REQUEST   = 8'd3;
    localparam logic [7:0] TYPE_STDOUT        = 8'd6;
    localparam logic [7:0] TYPE_STDERR        = 8'd7;
    localparam int         BYTES_PER_PHASE    = 165;
    localparam int         REPORT_LIMIT       = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       msg_end;
    } msg_byte_t;

    typedef struct packed {
        logic [7:0]  value;
        byte_class_t cls;
        logic [7:0]  rtype;
        logic [15:0] request;
        logic        rec_end;
        logic        pair_end;
        err_t        fault;
    } tagged_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    fastcgi_record_deframer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    msg_byte_t    pending_bytes[$];
    tagged_byte_t tagged_due[$];
    logic [7:0]   record_body[$];
    int           queued_count = 0;
    int           accepted_count = 0;
    int           fault_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           beat_taken = 1'b0;

    // Deframer state as the bench predicts it; all clear after reset.
    logic [3:0]   hdr_index = '0;
    logic [7:0]   rec_type = '0;
    logic [15:0]  rec_request = '0;
    logic [15:0]  content_remaining = '0;
    logic [7:0]   padding_remaining = '0;
    pair_phase_t  pair_state = PH_NAME_LEN;
    logic [6:0]   name_remaining = '0;
    logic [6:0]   value_remaining = '0;
    logic [15:0]  message_id = '0;
    logic         id_latched = 1'b0;
    err_t         first_fault = ERR_NONE;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The first fault of a message is kept until the message ends.
    function automatic void note_fault(input err_t code);
        if (first_fault == ERR_NONE)
            first_fault = code;
    endfunction

    function automatic void drop_pair();
        pair_state = PH_NAME_LEN;
        name_remaining = '0;
        value_remaining = '0;
    endfunction

    function automatic bit served_type(input logic [7:0] t);
        case (t)
            TYPE_BEGIN_REQUEST, TYPE_END_REQUEST, TYPE_PARAMS, TYPE_STDIN,
            TYPE_STDOUT, TYPE_STDERR: served_type = 1'b1;
            default:                  served_type = 1'b0;
        endcase
    endfunction

    // Advances the predicted framing state by one byte and returns its tags.
    function automatic tagged_byte_t deframe_byte(input logic [7:0] b, input logic msg_end);
        tagged_byte_t r;
        r.cls = CLS_HEADER;
        r.rec_end = 1'b0;
        r.pair_end = 1'b0;
        if (hdr_index < HDR_BYTES)
        begin
            // Header: version, type, id high/low, length high/low, padding, reserved.
            case (hdr_index)
                4'd0: if (b != FCGI_VERSION) note_fault(ERR_VERSION);
                4'd1:
                begin
                    rec_type = b;
                    if (!served_type(b))
                        note_fault(ERR_TYPE);
                end
                4'd2: rec_request[15:8] = b;
                4'd3:
                begin
                    rec_request[7:0] = b;
                    if (!id_latched)
                    begin
                        message_id = rec_request;
                        id_latched = (rec_request != 16'd0);
                    end
                    else if (message_id != rec_request)
                    begin
                        note_fault(ERR_REQUEST);
                    end
                end
                4'd4: content_remaining[15:8] = b;
                4'd5: content_remaining[7:0] = b;
                4'd6: padding_remaining = b;
                default: drop_pair();
            endcase
            hdr_index = hdr_index + 4'd1;
        end
        else if (content_remaining != 16'd0)
        begin
            content_remaining = content_remaining - 16'd1;
            if (rec_type == TYPE_PARAMS)
            begin
                case (pair_state)
                    PH_NAME_LEN:
                    begin
                        r.cls = CLS_PAIR_LEN;
                        if (b[7])
                            note_fault(ERR_LONG_LEN);
                        name_remaining = b[6:0];
                        pair_state = PH_VALUE_LEN;
                    end
                    PH_VALUE_LEN:
                    begin
                        r.cls = CLS_PAIR_LEN;
                        if (b[7])
                            note_fault(ERR_LONG_LEN);
                        value_remaining = b[6:0];
                        if (name_remaining == '0 && value_remaining == '0)
                        begin
                            r.pair_end = 1'b1;
                            pair_state = PH_NAME_LEN;
                        end
                        else
                        begin
                            pair_state = PH_BYTES;
                        end
                    end
                    default:
                    begin
                        if (name_remaining != '0)
                        begin
                            r.cls = CLS_NAME;
                            name_remaining = name_remaining - 7'd1;
                        end
                        else
                        begin
                            r.cls = CLS_VALUE;
                            if (value_remaining != '0)
                                value_remaining = value_remaining - 7'd1;
                        end
                        if (name_remaining == '0 && value_remaining == '0)
                        begin
                            r.pair_end = 1'b1;
                            pair_state = PH_NAME_LEN;
                        end
                    end
                endcase
                // Content running out in the middle of a pair is an overrun.
                if (content_remaining == 16'd0)
                begin
                    if (pair_state != PH_NAME_LEN)
                        note_fault(ERR_OVERRUN);
                    drop_pair();
                end
            end
            else if (rec_type == TYPE_STDIN)
            begin
                r.cls = CLS_STDIN;
            end
            else
            begin
                r.cls = CLS_OTHER;
            end
        end
        else
        begin
            r.cls = CLS_PADDING;
            if (padding_remaining != 8'd0)
                padding_remaining = padding_remaining - 8'd1;
        end

        if (hdr_index >= HDR_BYTES && content_remaining == 16'd0 &&
            padding_remaining == 8'd0)
        begin
            r.rec_end = 1'b1;
            hdr_index = '0;
        end

        r.value = b;
        r.rtype = rec_type;
        r.request = rec_request;
        r.fault = first_fault;

        // The end of a message drops any partial record and the request latch.
        if (msg_end)
        begin
            hdr_index = '0;
            content_remaining = '0;
            padding_remaining = '0;
            drop_pair();
            message_id = '0;
            id_latched = 1'b0;
            first_fault = ERR_NONE;
        end
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] d, input logic msg_end);
        msg_byte_t item;
        item.data = d;
        item.msg_end = msg_end;
        pending_bytes.insert(pending_bytes.size(), item);
        queued_count++;
    endtask

    // Sends a header, the body held in record_body and random padding; keep
    // cuts the record short, and the final byte sent may close the message.
    task automatic emit_record(input logic [7:0] ver, input logic [7:0] rtype,
                               input logic [15:0] req, input logic [15:0] clen,
                               input logic [7:0] pad_len, input int keep,
                               input bit ends_message);
        logic [7:0] frame[$];
        int         n;
        frame.insert(frame.size(), ver);
        frame.insert(frame.size(), rtype);
        frame.insert(frame.size(), req[15:8]);
        frame.insert(frame.size(), req[7:0]);
        frame.insert(frame.size(), clen[15:8]);
        frame.insert(frame.size(), clen[7:0]);
        frame.insert(frame.size(), pad_len);
        frame.insert(frame.size(), 8'($urandom_range(255)));
        foreach (record_body[i])
            frame.insert(frame.size(), record_body[i]);
        repeat (pad_len)
            frame.insert(frame.size(), 8'($urandom_range(255)));
        n = (keep < 0 || keep > frame.size()) ? frame.size() : keep;
        for (int i = 0; i < n; i++)
            queue_byte(frame[i], ends_message && (i == n - 1));
    endtask

    // Name-value pairs with short lengths, now and then a long-form length
    // byte or a body cut short so that the last pair may overrun.
    task automatic params_body();
        int         pairs;
        int         cut;
        logic [6:0] nl;
        logic [6:0] vl;
        pairs = int'($urandom_range(0, 3));
        for (int p = 0; p < pairs; p++)
        begin
            nl = 7'($urandom_range(0, 6));
            vl = 7'($urandom_range(0, 6));
            record_body.insert(record_body.size(), {($urandom_range(99) < 4), nl});
            record_body.insert(record_body.size(), {($urandom_range(99) < 4), vl});
            repeat (int'(nl) + int'(vl))
                record_body.insert(record_body.size(), 8'($urandom_range(255)));
        end
        if (record_body.size() != 0 && $urandom_range(99) < 12)
        begin
            cut = int'($urandom_range(1, record_body.size()));
            repeat (cut)
                record_body.delete(record_body.size() - 1);
        end
    endtask

    task automatic random_message();
        int          records;
        int          pick;
        int          keep;
        int          n;
        logic [15:0] msg_id;
        logic [15:0] req;
        logic [7:0]  ver;
        logic [7:0]  rtype;
        logic [7:0]  pad_len;
        if ($urandom_range(99) < 6)
        begin
            // Line noise: a few arbitrary bytes closed as a message.
            n = int'($urandom_range(1, 12));
            for (int i = 0; i < n; i++)
                queue_byte(8'($urandom_range(255)), i == n - 1);
            return;
        end
        records = int'($urandom_range(1, 4));
        msg_id = 16'($urandom_range(1, 65535));
        for (int r = 0; r < records; r++)
        begin
            ver = ($urandom_range(99) < 5) ? 8'($urandom_range(255)) : FCGI_VERSION;
            pick = int'($urandom_range(99));
            record_body.delete();
            if (pick < 40)
            begin
                rtype = TYPE_PARAMS;
                params_body();
            end
            else
            begin
                if (pick < 65)
                begin
                    rtype = TYPE_STDIN;
                end
                else if (pick < 92)
                begin
                    case ($urandom_range(3))
                        0:       rtype = TYPE_BEGIN_REQUEST;
                        1:       rtype = TYPE_END_REQUEST;
                        2:       rtype = TYPE_STDOUT;
                        default: rtype = TYPE_STDERR;
                    endcase
                end
                else
                begin
                    rtype = 8'($urandom_range(255));
                end
                n = int'($urandom_range(0, 10));
                repeat (n)
                    record_body.insert(record_body.size(), 8'($urandom_range(255)));
            end
            pick = int'($urandom_range(99));
            if (pick < 82)
                req = msg_id;
            else if (pick < 90)
                req = 16'd0;
            else
                req = 16'($urandom_range(65535));
            pad_len = ($urandom_range(99) < 40) ? 8'd0 : 8'($urandom_range(1, 7));
            keep = -1;
            if (r == records - 1 && $urandom_range(99) < 12)
                keep = int'($urandom_range(1, 8 + record_body.size() + pad_len));
            emit_record(ver, rtype, req, 16'(record_body.size()), pad_len, keep,
                        r == records - 1);
        end
    endtask

    task automatic directed_messages();
        // An empty record with a wrong version and an unserved type; the
        // version fault is kept and the record ends on its reserved byte.
        record_body.delete();
        emit_record(8'h00, TYPE_ABORT_REQUEST, 16'h0000, 16'h0000, 8'h00, -1, 1'b1);
        // Params under request id zero: an empty pair, then a pair that the
        // content cuts off before its value byte, then one padding byte.
        record_body.delete();
        record_body.insert(record_body.size(), 8'h00);
        record_body.insert(record_body.size(), 8'h00);
        record_body.insert(record_body.size(), 8'h02);
        record_body.insert(record_body.size(), 8'h01);
        record_body.insert(record_body.size(), 8'h78);
        record_body.insert(record_body.size(), 8'h79);
        emit_record(FCGI_VERSION, TYPE_PARAMS, 16'h0000, 16'd6, 8'd1, -1, 1'b1);
        // Largest id, content and padding lengths, a long-form name length,
        // and the message closing long before the record would.
        record_body.delete();
        record_body.insert(record_body.size(), 8'hFF);
        emit_record(FCGI_VERSION, TYPE_PARAMS, 16'hFFFF, 16'hFFFF, 8'hFF, 9, 1'b1);
    endtask

    task automatic drain();
        while (accepted_count != queued_count || tagged_due.size() != 0)
            @(negedge clk);
    endtask

    // Driver: a byte stays offered until taken; inputs move on the falling edge.
    always @(negedge clk)
    begin
        msg_byte_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
            s_tlast <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || beat_taken)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.data;
                    s_tlast <= nxt.msg_end;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: the outgoing beat is checked before the incoming byte is
    // predicted, since a beat leaving at this edge belongs to an older byte.
    always @(posedge clk)
    begin
        tagged_byte_t want;
        tagged_byte_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.value = m_tdata[7:0];
                got.cls = byte_class_t'(m_tuser[2:0]);
                got.rtype = m_tdata[15:8];
                got.request = m_tdata[31:16];
                got.rec_end = m_tlast;
                got.pair_end = m_tuser[3];
                got.fault = err_t'(m_tdata[34:32]);
                if (tagged_due.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("%0t: beat with nothing due: tdata %010h tuser %h tlast %b",
                                 $realtime, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    want = tagged_due.pop_front();
                    if (got !== want || m_tdata[39:35] !== 5'd0)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: expected byte %02h class %0d type %02h id %04h",
                                     $realtime, want.value, want.cls, want.rtype, want.request);
                            $display("    end %b pair %b error %0d", want.rec_end,
                                     want.pair_end, want.fault);
                            $display("    got byte %02h class %0d type %02h id %04h",
                                     got.value, got.cls, got.rtype, got.request);
                            $display("    end %b pair %b error %0d spare %02h", got.rec_end,
                                     got.pair_end, got.fault, m_tdata[39:35]);
                        end
                    end
                end
            end
            beat_taken = s_tvalid && s_tready;
            if (beat_taken)
            begin
                tagged_due.insert(tagged_due.size(), deframe_byte(s_tdata, s_tlast));
                accepted_count++;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Three traffic phases; the sender holds off between them until
        // every byte sent so far has come back.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 58;
                    directed_messages();
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            begin
                int target;
                target = queued_count + BYTES_PER_PHASE;
                while (queued_count < target)
                    random_message();
            end
            drain();
        end

        repeat (4) @(negedge clk);
        if (tagged_due.size() != 0)
        begin
            fault_count++;
            $display("%0d tagged bytes never arrived", tagged_due.size());
        end
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/fcgi_pkg.sv
rtl/fastcgi_record_deframer_core.sv
bench/tb_fastcgi_record_deframer_core.sv
